// ----- sv/transport_frame_sync_crc_deframer_top_macros.svh -----
// Assertion macros shared by the checker of the transport frame deframer.
// Depends on nothing; included by the checker file.
`ifndef TRANSPORT_FRAME_SYNC_CRC_DEFRAMER_TOP_MACROS_SVH
`define TRANSPORT_FRAME_SYNC_CRC_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// ----- sv/tfsd_pkg.sv -----
// Types, constants and the CRC-16-CCITT byte step of the transport frame deframer.
// Depends on nothing.
package tfsd_pkg;

  localparam logic [7:0]  SYNC_HI      = 8'hFF;
  localparam logic [7:0]  SYNC_LO      = 8'h0F;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam int          HEADER_BYTES = 7;
  localparam int          LEN_BITS     = 15;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_SINGLE,
    RES_BURST
  } res_kind_e;

  // Result descriptor handed from the parser to the output stage.
  typedef struct packed {
    res_kind_e             kind;
    logic [7:0]            payload_byte;
    logic                  byte_valid;
    logic                  frame_type;
    logic [LEN_BITS-1:0]   frame_length;
    logic                  first_of_frame;
    logic                  last_of_frame;
  } res_t;

  // One byte through the CCITT polynomial, MSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

  localparam logic [15:0] CRC_AFTER_SYNC = crc_step(crc_step(CRC_INIT, SYNC_HI), SYNC_LO);

endpackage

// ----- sv/tfsd_if.sv -----
// Handshake channel interfaces of the transport frame deframer: input bytes and results.
// Depends on nothing.
interface tfsd_in_if #(
  parameter int GROUP_COUNT_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [7:0]                  data_byte;
  logic [GROUP_COUNT_BITS-1:0] bytes_left;

  modport source (output valid, output data_byte, output bytes_left, input ready);
  modport sink (input valid, input data_byte, input bytes_left, output ready);
endinterface

interface tfsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        frame_type;
  logic [14:0] frame_length;
  logic        first_of_frame;
  logic        last_of_frame;
  logic        last_of_burst;

  modport source (output valid, output payload_byte, output byte_valid, output frame_type,
                  output frame_length, output first_of_frame, output last_of_frame,
                  output last_of_burst, input ready);
  modport sink (input valid, input payload_byte, input byte_valid, input frame_type,
                input frame_length, input first_of_frame, input last_of_frame,
                input last_of_burst, output ready);
endinterface

// ----- sv/tfsd_parser.sv -----
// Frame parser: sync hunt, header capture, CRC check, prefix store and body pass.
// Depends on tfsd_pkg.
module tfsd_parser import tfsd_pkg::*; #(
  parameter int  PREFIX_BYTES     = 11,
  parameter int  GROUP_COUNT_BITS = 16,
  localparam int CW = $clog2(PREFIX_BYTES + 1),
  localparam int IW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [7:0]                  data_byte_i,
  input  logic [GROUP_COUNT_BITS-1:0] bytes_left_i,
  input  logic [IW-1:0]               rd_idx_i,
  output logic [7:0]                  rd_data_o,
  output res_t                        res_o,
  output logic [CW-1:0]               need_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PREFIX,
    PH_BODY,
    PH_DROP
  } phase_e;

  localparam logic [2:0] HDR_LEN_HI = 3'd0;
  localparam logic [2:0] HDR_LEN_LO = 3'd1;
  localparam logic [2:0] HDR_CRC_HI = 3'd2;
  localparam logic [2:0] HDR_CRC_LO = 3'd3;

  localparam int LW = ((GROUP_COUNT_BITS > LEN_BITS) ? GROUP_COUNT_BITS : LEN_BITS) + 1;

  phase_e                      phase_q, phase_d;
  logic [7:0]                  prev_byte_q, prev_byte_d;
  logic                        prev_valid_q, prev_valid_d;
  logic [2:0]                  hdr_cnt_q, hdr_cnt_d;
  logic [GROUP_COUNT_BITS-1:0] sync_left_q, sync_left_d;
  logic [LEN_BITS-1:0]         frame_len_q, frame_len_d;
  logic [15:0]                 rx_crc_q, rx_crc_d;
  logic                        type_q, type_d;
  logic [15:0]                 crc_q, crc_d;
  logic [CW-1:0]               pcount_q, pcount_d;
  logic [LEN_BITS-1:0]         body_left_q, body_left_d;
  logic [7:0]                  store_q [PREFIX_BYTES];

  logic [15:0]         crc_next;
  logic                crc_ok_next;
  logic [LEN_BITS-1:0] len_next;
  logic                len_too_long;
  logic [CW-1:0]       need;
  logic [CW-1:0]       pcount_inc;
  logic [LEN_BITS-1:0] body_dec;
  logic                store_we;

  assign crc_next     = crc_step(crc_q, data_byte_i);
  assign crc_ok_next  = ((crc_next ^ CRC_INIT) == rx_crc_q);
  assign len_next     = {frame_len_q[LEN_BITS-1:8], data_byte_i};
  assign len_too_long = (LW'(len_next) + LW'(HEADER_BYTES)) > LW'(sync_left_q);
  assign need         = (frame_len_q < LEN_BITS'(PREFIX_BYTES)) ? CW'(frame_len_q)
                                                                : CW'(PREFIX_BYTES);
  assign pcount_inc   = pcount_q + CW'(1);
  assign body_dec     = body_left_q - LEN_BITS'(1);
  assign store_we     = accept_i && (phase_q == PH_PREFIX) && (pcount_q < CW'(PREFIX_BYTES));
  assign need_o       = need;
  assign rd_data_o    = store_q[rd_idx_i];

  always_comb begin
    phase_d      = phase_q;
    prev_byte_d  = prev_byte_q;
    prev_valid_d = prev_valid_q;
    hdr_cnt_d    = hdr_cnt_q;
    sync_left_d  = sync_left_q;
    frame_len_d  = frame_len_q;
    rx_crc_d     = rx_crc_q;
    type_d       = type_q;
    crc_d        = crc_q;
    pcount_d     = pcount_q;
    body_left_d  = body_left_q;

    res_o                = '0;
    res_o.kind           = RES_NONE;
    res_o.frame_type     = type_q;
    res_o.frame_length   = frame_len_q;

    if (accept_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (prev_valid_q && (prev_byte_q == SYNC_HI) && (data_byte_i == SYNC_LO)) begin
            phase_d      = PH_HEADER;
            hdr_cnt_d    = '0;
            crc_d        = CRC_AFTER_SYNC;
            prev_valid_d = 1'b0;
          end else begin
            prev_byte_d  = data_byte_i;
            prev_valid_d = 1'b1;
            sync_left_d  = bytes_left_i;
          end
        end
        PH_HEADER: begin
          unique case (hdr_cnt_q)
            HDR_LEN_HI: begin
              crc_d       = crc_next;
              frame_len_d = {data_byte_i[6:0], 8'h00};
              if (data_byte_i[7]) begin
                phase_d = PH_DROP;
              end
            end
            HDR_LEN_LO: begin
              crc_d       = crc_next;
              frame_len_d = len_next;
              if (len_too_long) begin
                phase_d = PH_DROP;
              end
            end
            HDR_CRC_HI: rx_crc_d = {data_byte_i, rx_crc_q[7:0]};
            HDR_CRC_LO: rx_crc_d = {rx_crc_q[15:8], data_byte_i};
            default: begin
              // Type byte: closes the header and the zero-length frame.
              crc_d    = crc_next;
              pcount_d = '0;
              if (data_byte_i > 8'd1) begin
                phase_d = PH_DROP;
              end else begin
                type_d = data_byte_i[0];
                if (frame_len_q == '0) begin
                  if (crc_ok_next) begin
                    res_o.kind           = RES_SINGLE;
                    res_o.frame_type     = data_byte_i[0];
                    res_o.first_of_frame = 1'b1;
                    res_o.last_of_frame  = 1'b1;
                    phase_d              = PH_HUNT;
                    prev_valid_d         = 1'b0;
                  end else begin
                    phase_d = PH_DROP;
                  end
                end else begin
                  phase_d = PH_PREFIX;
                end
              end
            end
          endcase
          hdr_cnt_d = hdr_cnt_q + 3'd1;
        end
        PH_PREFIX: begin
          crc_d    = crc_next;
          pcount_d = pcount_inc;
          if (pcount_inc >= need) begin
            if (crc_ok_next) begin
              res_o.kind          = RES_BURST;
              res_o.byte_valid    = 1'b1;
              res_o.last_of_frame = (frame_len_q == LEN_BITS'(need));
              if (frame_len_q > LEN_BITS'(need)) begin
                body_left_d = frame_len_q - LEN_BITS'(need);
                phase_d     = PH_BODY;
              end else begin
                phase_d      = PH_HUNT;
                prev_valid_d = 1'b0;
              end
            end else begin
              phase_d = PH_DROP;
            end
          end
        end
        PH_BODY: begin
          body_left_d          = body_dec;
          res_o.kind           = RES_SINGLE;
          res_o.payload_byte   = data_byte_i;
          res_o.byte_valid     = 1'b1;
          res_o.last_of_frame  = (body_dec == '0);
          if (body_dec == '0) begin
            phase_d      = PH_HUNT;
            prev_valid_d = 1'b0;
          end
        end
        PH_DROP: ;
        default: phase_d = PH_HUNT;
      endcase

      // The group's last byte always returns the parser to the hunt.
      if (bytes_left_i == GROUP_COUNT_BITS'(1)) begin
        phase_d      = PH_HUNT;
        prev_valid_d = 1'b0;
        prev_byte_d  = '0;
        hdr_cnt_d    = '0;
        pcount_d     = '0;
        body_left_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      prev_byte_q  <= '0;
      prev_valid_q <= 1'b0;
      hdr_cnt_q    <= '0;
      sync_left_q  <= '0;
      frame_len_q  <= '0;
      rx_crc_q     <= '0;
      type_q       <= 1'b0;
      crc_q        <= CRC_INIT;
      pcount_q     <= '0;
      body_left_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      prev_byte_q  <= prev_byte_d;
      prev_valid_q <= prev_valid_d;
      hdr_cnt_q    <= hdr_cnt_d;
      sync_left_q  <= sync_left_d;
      frame_len_q  <= frame_len_d;
      rx_crc_q     <= rx_crc_d;
      type_q       <= type_d;
      crc_q        <= crc_d;
      pcount_q     <= pcount_d;
      body_left_q  <= body_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[pcount_q[IW-1:0]] <= data_byte_i;
    end
  end

endmodule

// ----- sv/tfsd_emitter.sv -----
// Output stage: one pending slot that also walks prefix bursts, then the result register.
// Depends on tfsd_pkg and tfsd_out_if.
module tfsd_emitter import tfsd_pkg::*; #(
  parameter int  PREFIX_BYTES = 11,
  localparam int CW = $clog2(PREFIX_BYTES + 1),
  localparam int IW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  output logic          in_ready_o,
  input  res_t          res_i,
  input  logic [CW-1:0] need_i,
  output logic [IW-1:0] rd_idx_o,
  input  logic [7:0]    rd_data_i,
  tfsd_out_if.source    out_o
);

  logic          pend_valid_q;
  res_t          pend_res_q;
  logic [CW-1:0] pend_need_q;
  logic [IW-1:0] pend_idx_q;

  logic          out_valid_q;
  logic [7:0]    out_payload_q;
  logic          out_byte_valid_q;
  logic          out_type_q;
  logic [14:0]   out_length_q;
  logic          out_first_q;
  logic          out_last_q;
  logic          out_burst_end_q;

  logic          pend_burst;
  logic          last_elem;
  logic          move;
  logic          pend_done;
  logic          load;
  logic [7:0]    cur_payload;
  logic          cur_first;
  logic          cur_last;

  assign pend_burst = (pend_res_q.kind == RES_BURST);
  assign last_elem  = !pend_burst || ((CW'(pend_idx_q) + CW'(1)) == pend_need_q);
  assign move       = pend_valid_q && (!out_valid_q || out_o.ready);
  assign pend_done  = move && last_elem;
  assign in_ready_o = !pend_valid_q || pend_done;
  assign load       = accept_i && (res_i.kind != RES_NONE);
  assign rd_idx_o   = pend_idx_q;

  // A burst element reads the prefix store; a single result carries its own byte.
  assign cur_payload = pend_burst ? rd_data_i : pend_res_q.payload_byte;
  assign cur_first   = pend_burst ? (pend_idx_q == '0) : pend_res_q.first_of_frame;
  assign cur_last    = pend_res_q.last_of_frame && last_elem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load) begin
        pend_valid_q <= 1'b1;
        pend_idx_q   <= '0;
      end else if (pend_done) begin
        pend_valid_q <= 1'b0;
      end else if (move) begin
        pend_idx_q <= pend_idx_q + IW'(1);
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pend_res_q  <= res_i;
      pend_need_q <= need_i;
    end
    if (move) begin
      out_payload_q    <= cur_payload;
      out_byte_valid_q <= pend_res_q.byte_valid;
      out_type_q       <= pend_res_q.frame_type;
      out_length_q     <= pend_res_q.frame_length;
      out_first_q      <= cur_first;
      out_last_q       <= cur_last;
      out_burst_end_q  <= last_elem;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.payload_byte   = out_payload_q;
  assign out_o.byte_valid     = out_byte_valid_q;
  assign out_o.frame_type     = out_type_q;
  assign out_o.frame_length   = out_length_q;
  assign out_o.first_of_frame = out_first_q;
  assign out_o.last_of_frame  = out_last_q;
  assign out_o.last_of_burst  = out_burst_end_q;

endmodule

// ----- sv/transport_frame_sync_crc_deframer_top.sv -----
// Top level of the transport frame deframer with sync hunt and CRC-16-CCITT check.
// Depends on tfsd_pkg, tfsd_if, tfsd_parser and tfsd_emitter.
//
// Input channel in_i: one data-group byte per transaction with the count of bytes
// left in the group (1 marks the last byte). Output channel out_o: payload bytes of
// frames whose header CRC checked good, with type, length and frame/burst flags.
// An empty frame gives a single result with byte_valid low.
// Each input byte is parsed in the cycle it is accepted; its result goes into the
// pending slot and then to the output register once that is empty or being taken.
// Throughput is one byte per cycle if the receiver keeps up. The exception is the
// byte that completes a frame's prefix: its burst of up to PREFIX_BYTES results
// drains from the prefix store one per cycle, as the receiver allows, through the
// pending slot, and the input is held off until the burst's last result moves to
// the output register. A stalled receiver fills the output register and then the
// pending slot; the input is taken again as soon as the pending slot frees.
// Reset clears the parser to sync hunt and empties both output stages.
module transport_frame_sync_crc_deframer_top import tfsd_pkg::*; #(
  parameter int PREFIX_BYTES     = 11,
  parameter int GROUP_COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfsd_in_if.sink   in_i,
  tfsd_out_if.source out_o
);

  localparam int CW = $clog2(PREFIX_BYTES + 1);
  localparam int IW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;

  logic          accept;
  logic          in_ready;
  res_t          res;
  logic [CW-1:0] need;
  logic [IW-1:0] rd_idx;
  logic [7:0]    rd_data;
  logic [GROUP_COUNT_BITS-1:0] bytes_left;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;
  assign bytes_left = in_i.bytes_left;

  tfsd_parser #(
    .PREFIX_BYTES     (PREFIX_BYTES),
    .GROUP_COUNT_BITS (GROUP_COUNT_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (in_i.data_byte),
    .bytes_left_i (bytes_left),
    .rd_idx_i     (rd_idx),
    .rd_data_o    (rd_data),
    .res_o        (res),
    .need_o       (need)
  );

  tfsd_emitter #(
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_ready_o (in_ready),
    .res_i      (res),
    .need_i     (need),
    .rd_idx_o   (rd_idx),
    .rd_data_i  (rd_data),
    .out_o      (out_o)
  );

endmodule

// ----- sv/tfsd_checker.sv -----
// Port-level checker of the transport frame deframer and its bind to the top level.
// Depends on transport_frame_sync_crc_deframer_top_macros.svh.
`include "transport_frame_sync_crc_deframer_top_macros.svh"

module tfsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_i,
  input logic       byte_valid_i,
  input logic       first_of_frame_i,
  input logic       last_of_frame_i,
  input logic       last_of_burst_i
);

  // A result waiting on the receiver stays put.
  `TFSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(payload_byte_i) && $stable(last_of_burst_i))

  // The notice of an empty frame is a whole frame and a whole burst on its own.
  `TFSD_ASSERT_IMPL(a_empty_notice, clk_i, rst_ni, out_valid_i && !byte_valid_i, first_of_frame_i && last_of_frame_i && last_of_burst_i)

  // A frame never ends in the middle of a transaction burst.
  `TFSD_ASSERT_IMPL(a_frame_end_burst, clk_i, rst_ni, out_valid_i && last_of_frame_i, last_of_burst_i)

  // Only the first result of a frame can be an empty-frame notice.
  `TFSD_ASSERT_IMPL(a_tail_has_byte, clk_i, rst_ni, out_valid_i && !first_of_frame_i, byte_valid_i)

endmodule

bind transport_frame_sync_crc_deframer_top tfsd_checker u_tfsd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .payload_byte_i   (out_o.payload_byte),
  .byte_valid_i     (out_o.byte_valid),
  .first_of_frame_i (out_o.first_of_frame),
  .last_of_frame_i  (out_o.last_of_frame),
  .last_of_burst_i  (out_o.last_of_burst)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for transport_frame_sync_crc_deframer_top: it sends data groups
// with framed payloads and checks each output transaction against a built-in deframer model.
// Depends on the tfsd_in_if and tfsd_out_if interfaces and on the deframer top level.
module tb_top;

  localparam int PREFIX_LEN    = 11;
  localparam int COUNT_BITS    = 16;
  localparam int BODY_CAP      = 48;
  localparam int RANDOM_BYTES  = 100;
  localparam int MIN_GROUPS    = 6;
  localparam int HOLDOFF_LEN   = 150;
  localparam int SETTLE_CYCLES = 30;

  localparam logic [7:0]  SYNC_FIRST  = 8'hFF;
  localparam logic [7:0]  SYNC_SECOND = 8'h0F;
  localparam logic [15:0] CCITT_POLY  = 16'h1021;
  localparam logic [15:0] CCITT_SEED  = 16'hFFFF;

  typedef enum logic [2:0] {ST_HUNT, ST_HEADER, ST_PREFIX, ST_BODY, ST_DROP} parse_state_e;
  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_e;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_type;
    logic [14:0] frame_length;
    logic        first_of_frame;
    logic        last_of_frame;
    logic        last_of_burst;
  } deframed_t;

  // One data group: optional noise, an optional frame, optional trailing bytes.
  typedef struct {
    int          noise;
    logic [15:0] len_field;
    logic [7:0]  type_byte;
    bit          corrupt;
    fill_e       fill;
    int          cut;           // bytes kept, -1 keeps all
    int          extra;         // added to bytes_left except at zero_at and the end_group byte
    int          zero_at;       // index that carries bytes_left 0, -1 for none
    bit          end_group;     // last byte carries bytes_left 1
    bit          sync_on;
    int          tail;
    int          want_results;  // -1 leaves the count to the model
  } group_spec_t;

  // noise, length, type, corrupt, fill, cut, extra, zero_at, end, sync, tail, results
  group_spec_t directed_cases [18] = '{
    '{3, 16'd0,     8'd0,   0, FILL_RANDOM, -1, 0,     -1, 1, 1, 0, 1},   // empty frame
    '{2, 16'd0,     8'd1,   1, FILL_RANDOM, -1, 0,     -1, 1, 1, 0, 0},   // bad CRC
    '{2, 16'd1,     8'd0,   0, FILL_ZEROS,  -1, 0,     -1, 1, 1, 0, 1},
    '{2, 16'd11,    8'd1,   0, FILL_ONES,   -1, 0,     -1, 1, 1, 0, 11},  // prefix only
    '{1, 16'd12,    8'd0,   0, FILL_RANDOM, -1, 0,     -1, 1, 1, 0, 12},
    '{2, 16'h8005,  8'd0,   0, FILL_RANDOM, -1, 0,     -1, 1, 1, 0, 0},   // length top bit
    '{2, 16'hFFFF,  8'd1,   0, FILL_ONES,   12, 0,     -1, 1, 1, 0, 0},
    '{2, 16'd20,    8'd0,   0, FILL_RANDOM, 19, 0,     -1, 1, 1, 0, 0},   // too long
    '{2, 16'd5,     8'd2,   0, FILL_RANDOM, -1, 0,     -1, 1, 1, 0, 0},   // bad type
    '{2, 16'd5,     8'hFF,  0, FILL_RANDOM, -1, 0,     -1, 1, 1, 0, 0},
    '{2, 16'h7FFF,  8'd0,   0, FILL_RANDOM, -1, 65478, -1, 1, 1, 0, 48},  // cut body
    '{2, 16'd5,     8'd0,   0, FILL_RANDOM, 3,  0,     -1, 1, 1, 0, 0},   // cut sync
    '{2, 16'd5,     8'd0,   0, FILL_RANDOM, 6,  10,    -1, 1, 1, 0, 0},   // cut header
    '{2, 16'd8,     8'd1,   0, FILL_RANDOM, 13, 10,    -1, 1, 1, 0, 0},   // cut prefix
    '{2, 16'd3,     8'd0,   0, FILL_RANDOM, -1, 0,     0,  1, 1, 0, 3},   // zero count
    '{2, 16'd2,     8'd1,   0, FILL_RANDOM, -1, 5,     -1, 0, 1, 0, 2},   // open group
    '{2, 16'd4,     8'd0,   0, FILL_RANDOM, -1, 0,     -1, 1, 1, 0, 4},
    '{2, 16'd15,    8'd1,   0, FILL_RANDOM, 22, 10,    -1, 1, 1, 0, 13}
  };

  logic clk;
  logic rst_n;

  tfsd_in_if #(.GROUP_COUNT_BITS(COUNT_BITS)) in_ch ();
  tfsd_out_if out_ch ();

  transport_frame_sync_crc_deframer_top #(
    .PREFIX_BYTES    (PREFIX_LEN),
    .GROUP_COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Deframer model state.
  parse_state_e parse_st       = ST_HUNT;
  logic [7:0]   prev_byte      = 8'h00;
  logic         prev_ok        = 1'b0;
  logic [2:0]   hdr_idx        = 3'd0;
  logic [15:0]  sync_left      = 16'd0;
  logic [14:0]  hdr_len        = 15'd0;
  logic [15:0]  hdr_crc        = 16'd0;
  logic         hdr_type       = 1'b0;
  logic [15:0]  crc_acc        = CCITT_SEED;
  logic [7:0]   prefix_buf [PREFIX_LEN];
  logic [3:0]   prefix_fill    = 4'd0;
  logic [14:0]  body_remaining = 15'd0;

  deframed_t frame_results_q [$];
  deframed_t oldest;
  int        results_predicted  = 0;
  int        bytes_sent         = 0;
  int        mismatches         = 0;
  int        sender_idle_pct    = 0;
  int        receiver_stall_pct = 0;
  int        holdoff_cycles     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] ccitt_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void queue_result(logic [7:0] payload, logic valid, logic first,
                                       logic last, logic burst);
    deframed_t r;
    r.payload_byte   = payload;
    r.byte_valid     = valid;
    r.frame_type     = hdr_type;
    r.frame_length   = hdr_len;
    r.first_of_frame = first;
    r.last_of_frame  = last;
    r.last_of_burst  = burst;
    frame_results_q.push_back(r);
    results_predicted++;
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic [15:0] left);
    int need;
    need = (hdr_len < PREFIX_LEN) ? int'(hdr_len) : PREFIX_LEN;
    case (parse_st)
      ST_HUNT: begin
        if (prev_ok && prev_byte == SYNC_FIRST && b == SYNC_SECOND) begin
          parse_st = ST_HEADER;
          hdr_idx  = 3'd0;
          crc_acc  = ccitt_update(ccitt_update(CCITT_SEED, SYNC_FIRST), SYNC_SECOND);
          prev_ok  = 1'b0;
        end else begin
          prev_byte = b;
          prev_ok   = 1'b1;
          sync_left = left;
        end
      end
      ST_HEADER: begin
        case (hdr_idx)
          3'd0: begin
            crc_acc = ccitt_update(crc_acc, b);
            hdr_len = {b[6:0], 8'h00};
            if (b[7]) parse_st = ST_DROP;
          end
          3'd1: begin
            crc_acc      = ccitt_update(crc_acc, b);
            hdr_len[7:0] = b;
            // The whole frame has to fit in what was left of the group at the sync word.
            if (int'(hdr_len) + 7 > int'(sync_left)) parse_st = ST_DROP;
          end
          3'd2: hdr_crc[15:8] = b;
          3'd3: hdr_crc[7:0] = b;
          default: begin
            crc_acc     = ccitt_update(crc_acc, b);
            prefix_fill = 4'd0;
            if (b > 8'd1) begin
              parse_st = ST_DROP;
            end else begin
              hdr_type = b[0];
              if (hdr_len == 15'd0) begin
                if (~crc_acc == hdr_crc) begin
                  queue_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
                  parse_st = ST_HUNT;
                  prev_ok  = 1'b0;
                end else begin
                  parse_st = ST_DROP;
                end
              end else begin
                parse_st = ST_PREFIX;
              end
            end
          end
        endcase
        hdr_idx = hdr_idx + 3'd1;
      end
      ST_PREFIX: begin
        prefix_buf[prefix_fill] = b;
        crc_acc     = ccitt_update(crc_acc, b);
        prefix_fill = prefix_fill + 4'd1;
        if (int'(prefix_fill) >= need) begin
          if (~crc_acc == hdr_crc) begin
            for (int k = 0; k < need; k++) begin
              queue_result(prefix_buf[k], 1'b1, k == 0,
                           (k + 1 == need) && (int'(hdr_len) == need), k + 1 == need);
            end
            if (int'(hdr_len) > need) begin
              body_remaining = hdr_len - 15'(need);
              parse_st       = ST_BODY;
            end else begin
              parse_st = ST_HUNT;
              prev_ok  = 1'b0;
            end
          end else begin
            parse_st = ST_DROP;
          end
        end
      end
      ST_BODY: begin
        body_remaining = body_remaining - 15'd1;
        queue_result(b, 1'b1, 1'b0, body_remaining == 15'd0, 1'b1);
        if (body_remaining == 15'd0) begin
          parse_st = ST_HUNT;
          prev_ok  = 1'b0;
        end
      end
      default: ;
    endcase

    if (left == 16'd1) begin
      parse_st       = ST_HUNT;
      prev_ok        = 1'b0;
      prev_byte      = 8'h00;
      hdr_idx        = 3'd0;
      prefix_fill    = 4'd0;
      body_remaining = 15'd0;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frame_results_q.size() == 0) begin
        $error("result transaction with no expected result (payload 0x%0h)",
               out_ch.payload_byte);
        mismatches++;
      end else begin
        oldest = frame_results_q.pop_front();
        check_field("payload_byte", oldest.payload_byte, out_ch.payload_byte);
        check_field("byte_valid", oldest.byte_valid, out_ch.byte_valid);
        check_field("frame_type", oldest.frame_type, out_ch.frame_type);
        check_field("frame_length", oldest.frame_length, out_ch.frame_length);
        check_field("first_of_frame", oldest.first_of_frame, out_ch.first_of_frame);
        check_field("last_of_frame", oldest.last_of_frame, out_ch.last_of_frame);
        check_field("last_of_burst", oldest.last_of_burst, out_ch.last_of_burst);
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holdoff_cycles > 0) begin
        out_ch.ready = 1'b0;
        holdoff_cycles--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  task automatic play_group(input group_spec_t g);
    logic [7:0]  stream [$];
    logic [7:0]  body [$];
    logic [7:0]  b;
    logic [15:0] crc;
    logic [15:0] left;
    int          len15;
    int          built;
    int          n;
    len15 = int'(g.len_field[14:0]);
    built = (len15 > BODY_CAP) ? BODY_CAP : len15;

    for (int i = 0; i < g.noise; i++) begin
      if (!g.sync_on) begin
        // Bare noise leans on the sync bytes so that partial and spurious syncs show up.
        if ($urandom_range(1)) b = $urandom_range(1) ? SYNC_FIRST : SYNC_SECOND;
        else b = 8'($urandom_range(255));
      end else begin
        case (g.fill)
          FILL_ZEROS: b = 8'h00;
          FILL_ONES:  b = 8'hFF;
          default: begin
            b = 8'($urandom_range(254));
            if (b == SYNC_SECOND) b = 8'hA5;
          end
        endcase
      end
      stream.push_back(b);
    end

    if (g.sync_on) begin
      for (int i = 0; i < built; i++) begin
        case (g.fill)
          FILL_ZEROS: body.push_back(8'h00);
          FILL_ONES:  body.push_back(8'hFF);
          default:    body.push_back(8'($urandom_range(255)));
        endcase
      end
      crc = ccitt_update(ccitt_update(CCITT_SEED, SYNC_FIRST), SYNC_SECOND);
      crc = ccitt_update(crc, g.len_field[15:8]);
      crc = ccitt_update(crc, g.len_field[7:0]);
      crc = ccitt_update(crc, g.type_byte);
      for (int i = 0; i < built && i < PREFIX_LEN; i++) crc = ccitt_update(crc, body[i]);
      crc = ~crc;
      if (g.corrupt) crc = crc ^ (16'd1 << $urandom_range(15));
      stream.push_back(SYNC_FIRST);
      stream.push_back(SYNC_SECOND);
      stream.push_back(g.len_field[15:8]);
      stream.push_back(g.len_field[7:0]);
      stream.push_back(crc[15:8]);
      stream.push_back(crc[7:0]);
      stream.push_back(g.type_byte);
      foreach (body[i]) stream.push_back(body[i]);
    end
    for (int i = 0; i < g.tail; i++) stream.push_back(8'($urandom_range(255)));

    if (g.cut >= 0) begin
      while (stream.size() > g.cut) void'(stream.pop_back());
    end
    n = stream.size();

    for (int i = 0; i < n; i++) begin
      left = 16'(n - i + g.extra);
      if (i == g.zero_at) left = 16'd0;
      if (g.end_group && i == n - 1) left = 16'd1;
      while ($urandom_range(99) < sender_idle_pct) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
      @(negedge clk);
      in_ch.valid      = 1'b1;
      in_ch.data_byte  = stream[i];
      in_ch.bytes_left = left;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      deframe_byte(stream[i], left);
      bytes_sent++;
    end
  endtask

  // Stops offering input and waits until every expected result transaction has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    group_spec_t g;
    int          r;
    int          grp;
    int          est;
    int          start_bytes;
    int          count_at_start;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.bytes_left = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < $size(directed_cases); i++) begin
      count_at_start = results_predicted;
      play_group(directed_cases[i]);
      if (directed_cases[i].want_results >= 0 &&
          results_predicted - count_at_start != directed_cases[i].want_results) begin
        $error("directed case %0d: %0d results predicted, %0d listed", i,
               results_predicted - count_at_start, directed_cases[i].want_results);
        mismatches++;
      end
    end

    grp         = 0;
    start_bytes = bytes_sent;
    while ((bytes_sent - start_bytes < RANDOM_BYTES) || (grp < MIN_GROUPS)) begin
      case (grp % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
        default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
      endcase
      // The receiver holds off while input keeps coming, so the block backs up.
      if (grp == 0) holdoff_cycles = HOLDOFF_LEN;
      if (grp == 4) drain_results();

      g.sync_on = ($urandom_range(99) >= 8);
      g.noise   = g.sync_on ? $urandom_range(4) : $urandom_range(12, 1);
      r = $urandom_range(99);
      if (r < 8) g.len_field = 16'd0;
      else if (r < 68) g.len_field = 16'($urandom_range(11, 1));
      else if (r < 93) g.len_field = 16'($urandom_range(24, 12));
      else g.len_field = 16'($urandom_range(65535));
      g.type_byte = ($urandom_range(99) < 92) ? 8'($urandom_range(1))
                                              : 8'($urandom_range(255));
      g.corrupt   = ($urandom_range(99) < 8);
      r = $urandom_range(99);
      g.fill = (r < 10) ? FILL_ZEROS : ((r < 20) ? FILL_ONES : FILL_RANDOM);
      g.tail = $urandom_range(3);
      est = g.noise + g.tail;
      if (g.sync_on) begin
        est += 7 + ((g.len_field[14:0] > BODY_CAP) ? BODY_CAP : int'(g.len_field[14:0]));
      end
      g.cut = ($urandom_range(99) < 12) ? $urandom_range(est, 1) : -1;
      if (g.len_field[14:0] > 24 || $urandom_range(99) < 20) g.extra = $urandom_range(65535 - est);
      else g.extra = 0;
      g.end_group    = (g.extra == 0) || ($urandom_range(99) < 60);
      g.zero_at      = ($urandom_range(99) < 3) ? 0 : -1;
      g.want_results = -1;
      play_group(g);
      grp++;
    end

    drain_results();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- transport_frame_sync_crc_deframer_top.f -----
+incdir+sv
sv/tfsd_pkg.sv
sv/tfsd_if.sv
sv/tfsd_parser.sv
sv/tfsd_emitter.sv
sv/transport_frame_sync_crc_deframer_top.sv
sv/tfsd_checker.sv
tb/tb_top.sv
